FILE: hdl/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA rasterizer package
// Shared constants, opcodes and payload types of the DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 16;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  pixel_valid;
        logic                  last;
    } out_t;

endpackage

`default_nettype wire

FILE: hdl/dda_div.sv
// ----------------------------------------------------------------------------
// DDA increment divider
// Restoring divider, one quotient bit per cycle. Computes
// (dividend << FRAC_BITS) / divisor for a dividend that never exceeds the
// divisor, so the quotient fits in FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_div #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [dda_pkg::COORD_BITS-1:0] dividend,
    input  wire logic [dda_pkg::COORD_BITS-1:0] divisor,
    output logic                               done,
    output logic [FRAC_BITS:0]                 quotient
);

    localparam int C       = dda_pkg::COORD_BITS;
    localparam int CNT_W   = $clog2(FRAC_BITS + 2);
    localparam int N_ITER  = FRAC_BITS + 1;

    logic [C:0]         rem_reg, rem_next;
    logic [C-1:0]       div_reg;
    logic [FRAC_BITS:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic       ge;
    logic [C:0] diff;
    logic [C:0] rem_sel;

    // The partial remainder stays below the divisor after the first step,
    // so shifting it left always fits in C+1 bits.
    always_comb begin
        ge        = rem_reg >= {1'b0, div_reg};
        diff      = rem_reg - {1'b0, div_reg};
        rem_sel   = ge ? diff : rem_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {1'b0, dividend};
            quo_next  = '0;
            cnt_next  = CNT_W'(N_ITER);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = {rem_sel[C-1:0], 1'b0};
            quo_next = {quo_reg[FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/dda_line_rasterizer.sv
// Every result appears in the output register in the cycle after its input transaction is accepted.
// A next transaction does not leave the block busy; the accumulator add runs in the accept cycle.
// A start transaction of nonzero length holds the block busy while the shared
// one-bit-per-cycle divider computes the x and then the y increment.
// Reset (aresetn low, synchronous) drops any active line and empties the output register.
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Fixed-point DDA: a start transaction returns its first endpoint and sets up the increments;
// a next on an active line steps the accumulators and returns one pixel, else an empty result.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dda_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output dda_pkg::out_t      m_data
);

    localparam int C     = dda_pkg::COORD_BITS;
    localparam int ACC_W = C + 1 + FRAC_BITS;
    localparam int INC_W = FRAC_BITS + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV_X = 2'd1;
    localparam logic [1:0] ST_DIV_Y = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [ACC_W-1:0] x_acc_reg, x_acc_next;
    logic [ACC_W-1:0] y_acc_reg, y_acc_next;
    logic [INC_W-1:0] x_inc_reg, x_inc_next;
    logic [INC_W-1:0] y_inc_reg, y_inc_next;
    logic [C:0]       left_reg, left_next;
    logic             active_reg, active_next;
    logic             x_neg_reg, x_neg_next;
    logic             y_neg_reg, y_neg_next;
    logic [C-1:0]     ady_reg, ady_next;
    logic [C-1:0]     step_reg, step_next;
    logic             m_valid_reg, m_valid_next;
    dda_pkg::out_t    m_data_reg, m_data_next;

    logic             accept;
    logic [C-1:0]     adx, ady, step;
    logic             x_neg, y_neg;
    logic             div_start;
    logic [C-1:0]     div_dividend;
    logic [C-1:0]     div_divisor;
    logic             div_done;
    logic [FRAC_BITS:0] div_quo;
    logic [INC_W-1:0] quo_ext;
    logic [INC_W-1:0] quo_neg;
    logic [ACC_W-1:0] x_sum, y_sum;

    function automatic logic [C-1:0] pixel_of(input logic [ACC_W-1:0] acc);
        logic [C-1:0] p;
        p = acc[ACC_W-1] ? '0 : acc[FRAC_BITS +: C];
        return p;
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        x_neg = s_data.x_end < s_data.x_start;
        y_neg = s_data.y_end < s_data.y_start;
        adx   = x_neg ? s_data.x_start - s_data.x_end : s_data.x_end - s_data.x_start;
        ady   = y_neg ? s_data.y_start - s_data.y_end : s_data.y_end - s_data.y_start;
        step  = (adx > ady) ? adx : ady;
    end

    // The x division is launched from the accept cycle, the y division on
    // the cycle the x quotient comes back.
    assign div_start    = (accept && s_data.opcode == dda_pkg::OP_START && step != '0)
                       || (state_reg == ST_DIV_X && div_done);
    assign div_dividend = (state_reg == ST_IDLE) ? adx  : ady_reg;
    assign div_divisor  = (state_reg == ST_IDLE) ? step : step_reg;

    dda_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_ext = {1'b0, div_quo};
    assign quo_neg = -quo_ext;
    assign x_sum   = x_acc_reg + {{(ACC_W-INC_W){x_inc_reg[INC_W-1]}}, x_inc_reg};
    assign y_sum   = y_acc_reg + {{(ACC_W-INC_W){y_inc_reg[INC_W-1]}}, y_inc_reg};

    always_comb begin
        state_next   = state_reg;
        x_acc_next   = x_acc_reg;
        y_acc_next   = y_acc_reg;
        x_inc_next   = x_inc_reg;
        y_inc_next   = y_inc_reg;
        left_next    = left_reg;
        active_next  = active_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        ady_next     = ady_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    if (s_data.opcode == dda_pkg::OP_START) begin
                        x_acc_next  = {1'b0, s_data.x_start, {FRAC_BITS{1'b0}}};
                        y_acc_next  = {1'b0, s_data.y_start, {FRAC_BITS{1'b0}}};
                        x_neg_next  = x_neg;
                        y_neg_next  = y_neg;
                        ady_next    = ady;
                        step_next   = step;
                        left_next   = {1'b0, step};
                        x_inc_next  = '0;
                        y_inc_next  = '0;
                        m_data_next.pixel_x     = s_data.x_start;
                        m_data_next.pixel_y     = s_data.y_start;
                        m_data_next.pixel_valid = 1'b1;
                        if (step == '0) begin
                            active_next        = 1'b0;
                            m_data_next.last   = 1'b1;
                        end else begin
                            active_next        = 1'b1;
                            m_data_next.last   = 1'b0;
                            state_next         = ST_DIV_X;
                        end
                    end else if (active_reg) begin
                        x_acc_next = x_sum;
                        y_acc_next = y_sum;
                        left_next  = left_reg - (C+1)'(1);
                        m_data_next.pixel_x     = pixel_of(x_sum);
                        m_data_next.pixel_y     = pixel_of(y_sum);
                        m_data_next.pixel_valid = 1'b1;
                        m_data_next.last        = (left_reg == (C+1)'(1));
                        if (left_reg == (C+1)'(1)) begin
                            active_next = 1'b0;
                        end
                    end else begin
                        m_data_next = '0;
                    end
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    x_inc_next = x_neg_reg ? quo_neg : quo_ext;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    y_inc_next = y_neg_reg ? quo_neg : quo_ext;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_acc_reg  <= x_acc_next;
        y_acc_reg  <= y_acc_next;
        x_inc_reg  <= x_inc_next;
        y_inc_reg  <= y_inc_next;
        x_neg_reg  <= x_neg_next;
        y_neg_reg  <= y_neg_next;
        ady_reg    <= ady_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: hdl/dda_checker.sv
// ----------------------------------------------------------------------------
// DDA rasterizer checker
// Port-level assertions for the DDA line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire dda_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire dda_pkg::out_t m_data
);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // A start transaction returns its first endpoint on the next cycle.
    a_start_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready && s_data.opcode == dda_pkg::OP_START
        |=> m_valid && m_data.pixel_valid
            && m_data.pixel_x == $past(s_data.x_start)
            && m_data.pixel_y == $past(s_data.y_start))
        else $error("start did not return its first pixel");

    // A line of nonzero length makes the block drop s_ready once its start is accepted.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready && s_data.opcode == dda_pkg::OP_START
        && (s_data.x_start != s_data.x_end || s_data.y_start != s_data.y_end)
        |=> !s_ready)
        else $error("input accepted during increment division");

    // The last flag only ever marks a real pixel.
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.pixel_valid)
        else $error("last flag on an empty result");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);

`default_nettype wire
